### sv/arl_pkg.sv
// package with operation and status codes and field widths of the array list engine
`timescale 1ns / 1ps

package arl_pkg;

  // input field widths
  localparam int OP_W  = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;

  // output field widths
  localparam int ST_W  = 2;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

### sv/array_list_engine.sv
// top level of the array list engine: sequencer around a single list memory
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values kept in one synchronous memory of
// LIST_DEPTH entries with a live count. Each input transaction carries an operation
// (clear, insert, delete, search, read) and yields exactly one result transaction.
// Only one operation is in flight; the result sits in an output register, so the next
// input is taken as soon as the sequencer is back in idle. The one-read one-write memory
// port walks one entry per cycle. The final state, which hands the result over, waits
// for as long as the previous result still waits in the output register.
module array_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[4:0], item_value[36:5], zero fill
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], found_index[5:2], read_value[37:6],
                                  // list_count[42:38], zero fill
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > arl_pkg::POS_W) ? CW : arl_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_FETCH,
    S_FIN
  } state_t;

  // list memory
  logic [arl_pkg::VAL_W-1:0] mem [LIST_DEPTH];
  logic [arl_pkg::VAL_W-1:0] mem_q;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [arl_pkg::VAL_W-1:0] mem_wd;
  logic                      mem_re;
  logic [AW-1:0]             mem_ra;

  // registers
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             ptr_r, ptr_nxt;
  logic [arl_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [arl_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]             wr_addr_r, wr_addr_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [arl_pkg::ST_W-1:0]  res_st_r, res_st_nxt;
  logic [AW-1:0]             res_idx_r, res_idx_nxt;
  logic [arl_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [47:0]               out_data_r, out_data_nxt;

  // input fields
  logic [arl_pkg::OP_W-1:0]  in_op;
  logic [PW-1:0]             in_pos;
  logic [arl_pkg::VAL_W-1:0] in_val;
  logic                      in_fire;
  logic                      out_free;

  assign in_op    = in_tuser;
  assign in_pos   = PW'(in_tdata[arl_pkg::POS_W-1:0]);
  assign in_val   = in_tdata[arl_pkg::POS_W +: arl_pkg::VAL_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer and memory port control
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    rd_pend_nxt = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    res_st_nxt  = res_st_r;
    res_idx_nxt = res_idx_r;
    res_val_nxt = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_re = 1'b0;
    mem_ra = ptr_r[AW-1:0];
    // a pending shift write always drains first
    mem_we = wr_pend_r;
    mem_wa = wr_addr_r;
    mem_wd = mem_q;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          pos_nxt     = in_pos;
          val_nxt     = in_val;
          res_st_nxt  = arl_pkg::ST_OK;
          res_idx_nxt = '0;
          res_val_nxt = '0;
          state_nxt   = S_FIN;
          case (in_op)
            arl_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            arl_pkg::OP_INSERT: begin
              if (count_r == DEPTH_C) begin
                res_st_nxt = arl_pkg::ST_FULL;
              end else if (in_pos > PW'(count_r)) begin
                res_st_nxt = arl_pkg::ST_BADPOS;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_SHIFT;
              end
            end
            arl_pkg::OP_DELETE: begin
              if (in_pos >= PW'(count_r)) begin
                res_st_nxt = arl_pkg::ST_BADPOS;
              end else begin
                ptr_nxt   = CW'(in_pos);
                state_nxt = S_SHIFT;
              end
            end
            arl_pkg::OP_SEARCH: begin
              res_st_nxt = arl_pkg::ST_NOTFOUND;
              ptr_nxt    = '0;
              state_nxt  = S_SCAN;
            end
            arl_pkg::OP_READ: begin
              if (in_pos >= PW'(count_r)) begin
                res_st_nxt = arl_pkg::ST_BADPOS;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // move entries one place, one read and one delayed write per cycle
      S_SHIFT: begin
        if (op_r == arl_pkg::OP_INSERT) begin
          if (PW'(ptr_r) > pos_r) begin
            mem_re      = 1'b1;
            mem_ra      = AW'(ptr_r - CW'(1));
            wr_pend_nxt = 1'b1;
            wr_addr_nxt = ptr_r[AW-1:0];
            ptr_nxt     = ptr_r - CW'(1);
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          if ((ptr_r + CW'(1)) < count_r) begin
            mem_re      = 1'b1;
            mem_ra      = AW'(ptr_r + CW'(1));
            wr_pend_nxt = 1'b1;
            wr_addr_nxt = ptr_r[AW-1:0];
            ptr_nxt     = ptr_r + CW'(1);
          end else begin
            state_nxt = S_PUT;
          end
        end
      end

      // wait for the last shift write, then place the value and update the count
      S_PUT: begin
        if (!wr_pend_r) begin
          if (op_r == arl_pkg::OP_INSERT) begin
            mem_we    = 1'b1;
            mem_wa    = pos_r[AW-1:0];
            mem_wd    = val_r;
            count_nxt = count_r + CW'(1);
          end else begin
            count_nxt = count_r - CW'(1);
          end
          state_nxt = S_FIN;
        end
      end

      // linear search, the compare happens in the cycle after the read
      S_SCAN: begin
        if (rd_pend_r && (mem_q == val_r)) begin
          res_st_nxt  = arl_pkg::ST_OK;
          res_idx_nxt = rd_idx_r;
          state_nxt   = S_FIN;
        end else if (ptr_r < count_r) begin
          mem_re      = 1'b1;
          mem_ra      = ptr_r[AW-1:0];
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end

      // single entry read
      S_FETCH: begin
        if (rd_pend_r) begin
          res_val_nxt = mem_q;
          state_nxt   = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_ra      = pos_r[AW-1:0];
          rd_pend_nxt = 1'b1;
        end
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, arl_pkg::CNT_W'(count_r), res_val_r,
                           arl_pkg::IDX_W'(res_idx_r), res_st_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    wr_addr_r  <= wr_addr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_val_r  <= res_val_nxt;
    out_data_r <= out_data_nxt;
  end

  // list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // the count never passes the list depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= DEPTH_C)
    else $error("list count above depth");

  // no shift write is left over once the sequencer is back in idle
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_IDLE) |-> !wr_pend_r)
    else $error("shift write pending in idle");

  // a finished result reaches the output register when it is free
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

  // a full status is only reported with a full list
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_FIN && res_st_r == arl_pkg::ST_FULL)
                   |-> (count_r == DEPTH_C))
    else $error("full status with room left");

endmodule
